// File: hw/rtl/slr_pkg.sv
// Shared constants, types and controller encodings for the shaded line rasteriser.
package slr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ADDR_W         = 32;
    localparam int PITCH_W        = 13;
    localparam int ROW_W          = 24;
    localparam int COLOR_W        = 8;
    localparam int FRAC_BITS      = 16;
    localparam int ACC_W          = 25;
    localparam int DIV_BITS       = COLOR_W + FRAC_BITS;
    localparam int CNT_W          = $clog2(DIV_BITS);
    localparam int CH_NUM         = 3;
    localparam int PIXEL_W        = 16;
    localparam int RED_W          = 5;
    localparam int GREEN_W        = 6;
    localparam int BLUE_W         = 5;
    localparam int RED_LSB        = 19;
    localparam int GREEN_LSB      = 18;
    localparam int BLUE_LSB       = 19;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 32;

    localparam logic [ADDR_W-1:0]  FRAME_BASE_RESET = '0;
    localparam logic [PITCH_W-1:0] LINE_PITCH_RESET = 13'd640;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_BASE = 1'b0,
        CFG_LINE_PITCH = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_DIVIDE,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load_start;
        logic setup_a;
        logic setup_b;
        logic div_step;
        logic div_finish;
        logic tick_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic line_active;
        logic len_zero;
        logic div_last;
        logic out_busy;
    } status_t;

endpackage

// File: hw/rtl/slr_if.sv
// Handshake interfaces for the line input, pixel output and register write channels.
interface slr_line_if
    import slr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_W-1:0]    red_start;
    logic [COLOR_W-1:0]    green_start;
    logic [COLOR_W-1:0]    blue_start;
    logic [COLOR_W-1:0]    red_end;
    logic [COLOR_W-1:0]    green_end;
    logic [COLOR_W-1:0]    blue_end;

    modport source (
        output valid, op, x_start, y_start, x_end, y_end,
               red_start, green_start, blue_start, red_end, green_end, blue_end,
        input  ready
    );
    modport sink (
        input  valid, op, x_start, y_start, x_end, y_end,
               red_start, green_start, blue_start, red_end, green_end, blue_end,
        output ready
    );
endinterface

interface slr_pixel_if
    import slr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  pixel_address;
    logic [PIXEL_W-1:0] pixel_value;
    logic               last_pixel;

    modport source (output valid, pixel_address, pixel_value, last_pixel, input ready);
    modport sink   (input valid, pixel_address, pixel_value, last_pixel, output ready);
endinterface

interface slr_cfg_if
    import slr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// File: hw/rtl/slr_ctrl.sv
// Sequencing state machine for the shaded line rasteriser.
module slr_ctrl
    import slr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = status.in_valid && (state_reg == ST_IDLE) && !status.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(status.in_op) == OP_START)
                    begin
                        state_next = ST_SETUP_A;
                    end
                    else if (status.line_active)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SETUP_A: state_next = ST_SETUP_B;
            ST_SETUP_B: state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (status.len_zero || status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:  state_next = ST_EMIT;
            ST_EMIT:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready   = !status.out_busy;
                cmd.load_start = accept && (op_t'(status.in_op) == OP_START);
                cmd.tick_step  = accept && (op_t'(status.in_op) == OP_TICK)
                                 && status.line_active;
            end
            ST_SETUP_A: cmd.setup_a    = 1'b1;
            ST_SETUP_B: cmd.setup_b    = 1'b1;
            ST_DIVIDE:  cmd.div_step   = !status.len_zero;
            ST_FINISH:  cmd.div_finish = 1'b1;
            ST_EMIT:    cmd.emit       = 1'b1;
            default:    cmd            = '0;
        endcase
    end

endmodule

// File: hw/rtl/slr_datapath.sv
// Line walking, colour division and pixel output registers of the shaded line rasteriser.
module slr_datapath
    import slr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    slr_line_if.sink           line_in,
    slr_pixel_if.source        pixel_out,
    slr_cfg_if.sink            cfg
);

    localparam int CW     = COORD_BITS;
    localparam int ERR_W  = COORD_BITS + 3;
    localparam int PROD_W = COORD_BITS + PITCH_W;
    localparam int OFS_W  = ROW_W + 1;

    // Configuration
    logic [ADDR_W-1:0]  frame_base_reg, frame_base_next;
    logic [PITCH_W-1:0] line_pitch_reg, line_pitch_next;

    // Latched start word
    logic [CW-1:0]      x0_reg, x0_next, y0_reg, y0_next;
    logic [CW-1:0]      x1_reg, x1_next, y1_reg, y1_next;
    logic [COLOR_W-1:0] c0_reg [CH_NUM];
    logic [COLOR_W-1:0] c0_next [CH_NUM];
    logic [COLOR_W-1:0] c1_reg [CH_NUM];
    logic [COLOR_W-1:0] c1_next [CH_NUM];
    logic [COLOR_W-1:0] c0_in [CH_NUM];
    logic [COLOR_W-1:0] c1_in [CH_NUM];

    // Walk state
    logic [CW-1:0]      column_reg, column_next;
    logic [ROW_W-1:0]   row_offset_reg, row_offset_next;
    logic               col_neg_reg, col_neg_next, row_neg_reg, row_neg_next;
    logic [CW-1:0]      dx_reg, dx_next, dy_reg, dy_next;
    logic               x_major_reg, x_major_next;
    logic [CW:0]        ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [CW-1:0]      remaining_reg, remaining_next;
    logic               line_active_reg, line_active_next;
    logic               last_reg, last_next;
    logic [ACC_W-1:0]   acc_reg [CH_NUM];
    logic [ACC_W-1:0]   acc_next [CH_NUM];
    logic [ACC_W-1:0]   step_reg [CH_NUM];
    logic [ACC_W-1:0]   step_next [CH_NUM];

    // Division lanes
    logic               chan_neg_reg [CH_NUM];
    logic               chan_neg_next [CH_NUM];
    logic [CW-1:0]      rem_reg [CH_NUM];
    logic [CW-1:0]      rem_next [CH_NUM];
    logic [DIV_BITS-1:0] quo_reg [CH_NUM];
    logic [DIV_BITS-1:0] quo_next [CH_NUM];
    logic [CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [CW:0]        trial [CH_NUM];
    logic               trial_fits [CH_NUM];

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [PIXEL_W-1:0] out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    // Helpers
    logic [PROD_W-1:0]  row_product;
    logic [CW-1:0]      len_sel;
    logic               err_ge;
    logic               move_row, move_col;
    logic [ERR_W-1:0]   err_tick;
    logic [ROW_W-1:0]   row_tick;
    logic [CW-1:0]      col_tick;
    logic [CW-1:0]      rem_tick;
    logic [OFS_W-1:0]   pixel_offset;
    logic               len_zero;

    assign c0_in[0] = line_in.red_start;
    assign c0_in[1] = line_in.green_start;
    assign c0_in[2] = line_in.blue_start;
    assign c1_in[0] = line_in.red_end;
    assign c1_in[1] = line_in.green_end;
    assign c1_in[2] = line_in.blue_end;

    assign line_in.ready = cmd.in_ready;
    assign cfg.ready     = 1'b1;

    assign pixel_out.valid         = out_valid_reg;
    assign pixel_out.pixel_address = out_addr_reg;
    assign pixel_out.pixel_value   = out_value_reg;
    assign pixel_out.last_pixel    = out_last_reg;

    assign len_zero = (remaining_reg == '0);

    assign status.in_valid    = line_in.valid;
    assign status.in_op       = line_in.op;
    assign status.line_active = line_active_reg;
    assign status.len_zero    = len_zero;
    assign status.div_last    = (div_cnt_reg == '0);
    assign status.out_busy    = out_valid_reg && !pixel_out.ready;

    assign row_product = PROD_W'(y0_reg) * PROD_W'(line_pitch_reg);
    assign len_sel     = (dx_reg > dy_reg) ? dx_reg : dy_reg;

    // One Bresenham step: the error sign picks whether the minor axis moves.
    assign err_ge   = ~err_reg[ERR_W-1];
    assign move_row = ~x_major_reg | err_ge;
    assign move_col = x_major_reg | err_ge;
    assign err_tick = x_major_reg
                    ? err_reg + ERR_W'(ddy_reg) - (err_ge ? ERR_W'(ddx_reg) : '0)
                    : err_reg + ERR_W'(ddx_reg) - (err_ge ? ERR_W'(ddy_reg) : '0);
    assign row_tick = !move_row ? row_offset_reg
                    : row_neg_reg ? row_offset_reg - ROW_W'(line_pitch_reg)
                    : row_offset_reg + ROW_W'(line_pitch_reg);
    assign col_tick = !move_col ? column_reg
                    : col_neg_reg ? column_reg - CW'(1)
                    : column_reg + CW'(1);
    assign rem_tick = remaining_reg - CW'(1);

    assign pixel_offset = OFS_W'(column_reg) + OFS_W'(row_offset_reg);

    for (genvar k = 0; k < CH_NUM; k++)
    begin : g_lane
        assign trial[k]      = {rem_reg[k], quo_reg[k][DIV_BITS-1]};
        assign trial_fits[k] = (trial[k] >= {1'b0, remaining_reg});
    end

    always_comb
    begin
        frame_base_next  = frame_base_reg;
        line_pitch_next  = line_pitch_reg;
        x0_next          = x0_reg;
        y0_next          = y0_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        column_next      = column_reg;
        row_offset_next  = row_offset_reg;
        col_neg_next     = col_neg_reg;
        row_neg_next     = row_neg_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        x_major_next     = x_major_reg;
        ddx_next         = ddx_reg;
        ddy_next         = ddy_reg;
        err_next         = err_reg;
        remaining_next   = remaining_reg;
        line_active_next = line_active_reg;
        last_next        = last_reg;
        div_cnt_next     = div_cnt_reg;
        out_valid_next   = out_valid_reg;
        out_addr_next    = out_addr_reg;
        out_value_next   = out_value_reg;
        out_last_next    = out_last_reg;
        for (int k = 0; k < CH_NUM; k++)
        begin
            c0_next[k]       = c0_reg[k];
            c1_next[k]       = c1_reg[k];
            acc_next[k]      = acc_reg[k];
            step_next[k]     = step_reg[k];
            chan_neg_next[k] = chan_neg_reg[k];
            rem_next[k]      = rem_reg[k];
            quo_next[k]      = quo_reg[k];
        end

        if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.reg_index))
                CFG_FRAME_BASE: frame_base_next = ADDR_W'(cfg.reg_data);
                CFG_LINE_PITCH: line_pitch_next = PITCH_W'(cfg.reg_data);
            endcase
        end

        if (cmd.load_start)
        begin
            x0_next = line_in.x_start;
            y0_next = line_in.y_start;
            x1_next = line_in.x_end;
            y1_next = line_in.y_end;
            for (int k = 0; k < CH_NUM; k++)
            begin
                c0_next[k] = c0_in[k];
                c1_next[k] = c1_in[k];
            end
        end

        if (cmd.setup_a)
        begin
            col_neg_next    = (x1_reg < x0_reg);
            row_neg_next    = (y1_reg < y0_reg);
            dx_next         = (x1_reg < x0_reg) ? x0_reg - x1_reg : x1_reg - x0_reg;
            dy_next         = (y1_reg < y0_reg) ? y0_reg - y1_reg : y1_reg - y0_reg;
            column_next     = x0_reg;
            row_offset_next = ROW_W'(row_product);
            for (int k = 0; k < CH_NUM; k++)
            begin
                chan_neg_next[k] = (c1_reg[k] < c0_reg[k]);
                quo_next[k]      = {((c1_reg[k] < c0_reg[k]) ? c0_reg[k] - c1_reg[k]
                                                            : c1_reg[k] - c0_reg[k]),
                                    FRAC_BITS'(0)};
                rem_next[k]      = '0;
            end
        end

        if (cmd.setup_b)
        begin
            x_major_next     = (dx_reg > dy_reg);
            ddx_next         = {dx_reg, 1'b0};
            ddy_next         = {dy_reg, 1'b0};
            err_next         = (dx_reg > dy_reg)
                             ? ERR_W'({dy_reg, 1'b0}) - ERR_W'(dx_reg)
                             : ERR_W'({dx_reg, 1'b0}) - ERR_W'(dy_reg);
            remaining_next   = len_sel;
            line_active_next = (len_sel != '0);
            last_next        = (len_sel == '0);
            div_cnt_next     = CNT_W'(DIV_BITS - 1);
            for (int k = 0; k < CH_NUM; k++)
            begin
                acc_next[k] = ACC_W'({c0_reg[k], FRAC_BITS'(0)});
            end
        end

        if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg - CNT_W'(1);
            for (int k = 0; k < CH_NUM; k++)
            begin
                rem_next[k] = trial_fits[k] ? CW'(trial[k] - {1'b0, remaining_reg})
                                            : CW'(trial[k]);
                quo_next[k] = {quo_reg[k][DIV_BITS-2:0], trial_fits[k]};
            end
        end

        if (cmd.div_finish)
        begin
            for (int k = 0; k < CH_NUM; k++)
            begin
                step_next[k] = len_zero ? '0
                             : chan_neg_reg[k] ? ACC_W'(0) - ACC_W'(quo_reg[k])
                             : ACC_W'(quo_reg[k]);
            end
        end

        if (cmd.tick_step)
        begin
            err_next         = err_tick;
            row_offset_next  = row_tick;
            column_next      = col_tick;
            remaining_next   = rem_tick;
            line_active_next = (rem_tick != '0);
            last_next        = (rem_tick == '0);
            for (int k = 0; k < CH_NUM; k++)
            begin
                acc_next[k] = acc_reg[k] + step_reg[k];
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = frame_base_reg + ADDR_W'({pixel_offset, 1'b0});
            out_value_next = {acc_reg[0][RED_LSB +: RED_W],
                              acc_reg[1][GREEN_LSB +: GREEN_W],
                              acc_reg[2][BLUE_LSB +: BLUE_W]};
            out_last_next  = last_reg;
        end
        else if (pixel_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg  <= FRAME_BASE_RESET;
            line_pitch_reg  <= LINE_PITCH_RESET;
            line_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            frame_base_reg  <= frame_base_next;
            line_pitch_reg  <= line_pitch_next;
            line_active_reg <= line_active_next;
            out_valid_reg   <= out_valid_next;
            div_cnt_reg     <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        x1_reg         <= x1_next;
        y1_reg         <= y1_next;
        column_reg     <= column_next;
        row_offset_reg <= row_offset_next;
        col_neg_reg    <= col_neg_next;
        row_neg_reg    <= row_neg_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        x_major_reg    <= x_major_next;
        ddx_reg        <= ddx_next;
        ddy_reg        <= ddy_next;
        err_reg        <= err_next;
        remaining_reg  <= remaining_next;
        last_reg       <= last_next;
        out_addr_reg   <= out_addr_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        for (int k = 0; k < CH_NUM; k++)
        begin
            c0_reg[k]       <= c0_next[k];
            c1_reg[k]       <= c1_next[k];
            acc_reg[k]      <= acc_next[k];
            step_reg[k]     <= step_next[k];
            chan_neg_reg[k] <= chan_neg_next[k];
            rem_reg[k]      <= rem_next[k];
            quo_reg[k]      <= quo_next[k];
        end
    end

endmodule

// File: hw/rtl/shaded_line_rasterizer_rgb565.sv
// Start word: SETUP_A, SETUP_B, DIVIDE (24 divider steps, none at zero length), FINISH, EMIT.
// Tick word: pixel from the EMIT state; the next word waits until after EMIT and a free output.
// The rate of start words is set by the three-lane restoring divider, one quotient bit a cycle.
// Reset (rst_n, asynchronous, active low) idles the sequencer, drops any active line,
// empties the output register and returns frame_base to 0 and line_pitch to 640.
// No memory needs clearing, so a word can be taken straight after reset.
module shaded_line_rasterizer_rgb565
    import slr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    slr_line_if.sink    line_in,
    slr_pixel_if.source pixel_out,
    slr_cfg_if.sink     cfg
);

    // The controller sees only status flags and drives only command strobes; all
    // arithmetic, the configuration registers and the output register sit in the
    // datapath. The output register lets a new word be taken in the same cycle as
    // the previous pixel word leaves.
    cmd_t    cmd;
    status_t status;

    slr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath walks the line with Bresenham's error term, keeps the row as a
    // running offset of row times pitch, and steps three 9.16 colour accumulators.
    // The colour steps come from a restoring divider with one lane per channel.
    slr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .line_in   (line_in),
        .pixel_out (pixel_out),
        .cfg       (cfg)
    );

endmodule
